// File: rtl/csvg_pkg.sv
package csvg_pkg;

  // Sine table: quarter wave, entries 0..SINE_TABLE_DEPTH, Q1.14 magnitudes
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TRIG_W           = 15;            // holds 0..16384
  localparam int TRIG_FRAC        = 14;
  localparam int TRIG_ONE         = 16384;

  // Coordinates and internal exact sums
  localparam int COORD_W    = 24;
  localparam int EXTRA_BITS = 29;                  // extra fraction bits before rounding
  localparam int SUM_W      = 56;
  localparam int N_COORD    = 10;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W     = 16;
  localparam int DIM_W      = 23;
  localparam logic signed [GAIN_W-1:0] DEPTH_GAIN_RST = 16'sd3277;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RECT_LEFT   = 3'd0,
    REG_RECT_TOP    = 3'd1,
    REG_RECT_WIDTH  = 3'd2,
    REG_RECT_HEIGHT = 3'd3,
    REG_DEPTH_GAIN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] idx;
  } sine_idx_t;

  typedef logic [TRIG_W-1:0] sine_lut_t [SINE_TABLE_DEPTH+1];

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Q30 Horner series for sin(pi/2 * i / depth), rounded to Q1.14 and capped at one
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t   lut;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      th = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2 = (th * th) >> 30;
      r  = Q30_ONE;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd110;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd72;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd42;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd20;
      r  = Q30_ONE - ((x2 * r) >> 30) / 64'd6;
      v  = (th * r) >> 30;
      v  = (v + 64'd32768) >> 16;
      if (v > 64'(TRIG_ONE)) begin
        v = 64'(TRIG_ONE);
      end
      lut[i] = v[TRIG_W-1:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

// File: rtl/card_spin_vertex_generator_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid_i/tready_o     tuser: cmd; tdata: angle
// m_axis    out  m_axis_tvalid_o/tready_i     tdata: centre, corners a..d (x, y each)
// cfg       in   cfg_we_i                     cfg_addr_i selects, cfg_wdata_i holds value
//
// Six register stages: sine index, table read, depth/sine terms, multiplies,
// exact sums, round and saturate. One item per cycle while the output is not stalled.
// Every stage carries its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles close up and a stall at the output only
// holds back items behind it. Reset clears the valid bits and loads register
// defaults (depth gain 3277, about 0.2; others zero).
module card_spin_vertex_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // stream in
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [15:0]                         s_axis_tdata_i,  // [15:0] angle
  input  logic                                s_axis_tuser_i,  // [0] cmd
  // stream out
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [23:0] centre_x, [47:24] centre_y, [71:48] corner_a_x, [95:72] corner_a_y,
  // [119:96] corner_b_x, [143:120] corner_b_y, [167:144] corner_c_x,
  // [191:168] corner_c_y, [215:192] corner_d_x, [239:216] corner_d_y
  output logic [csvg_pkg::N_COORD*csvg_pkg::COORD_W-1:0] m_axis_tdata_o,
  // register writes
  input  logic                                cfg_we_i,
  input  logic [csvg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [csvg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import csvg_pkg::*;

  localparam int NStages = 6;
  localparam int PmW     = TRIG_W + 1 + DIM_W;   // (one +/- s) * dimension
  localparam int KW      = 32;                   // c * gain
  localparam int RndW    = SUM_W - EXTRA_BITS;

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic signed [COORD_W-1:0] rect_left_q, rect_top_q;
  logic        [DIM_W-1:0]   rect_width_q, rect_height_q;
  logic signed [GAIN_W-1:0]  depth_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_left_q   <= '0;
      rect_top_q    <= '0;
      rect_width_q  <= '0;
      rect_height_q <= '0;
      depth_gain_q  <= DEPTH_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_RECT_LEFT:   rect_left_q   <= cfg_wdata_i;
        REG_RECT_TOP:    rect_top_q    <= cfg_wdata_i;
        REG_RECT_WIDTH:  rect_width_q  <= cfg_wdata_i[DIM_W-1:0];
        REG_RECT_HEIGHT: rect_height_q <= cfg_wdata_i[DIM_W-1:0];
        REG_DEPTH_GAIN:  depth_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage flow control
  // ------------------------------------------------------------------
  logic [NStages-1:0] v_q;
  logic [NStages-1:0] en;

  always_comb begin
    en[NStages-1] = !v_q[NStages-1] || m_axis_tready_i;
    for (int k = NStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready_o = en[0];
  assign m_axis_tvalid_o = v_q[NStages-1];

  // ------------------------------------------------------------------
  // Stage 1: table index and sign per quadrant
  // ------------------------------------------------------------------
  function automatic sine_idx_t sine_index(input logic [15:0] turn);
    localparam int PW = TRIG_FRAC + IDX_W + 1;
    sine_idx_t   res;
    logic [PW-1:0] scaled;
    scaled  = PW'(turn[13:0]) * PW'(SINE_TABLE_DEPTH) + PW'(1 << (TRIG_FRAC - 1));
    res.idx = scaled[TRIG_FRAC +: IDX_W];
    if (turn[14]) begin
      res.idx = IDX_W'(SINE_TABLE_DEPTH) - res.idx;
    end
    res.neg = turn[15];
    return res;
  endfunction

  logic            s1_cmd_q;
  sine_idx_t       s1_sin_q, s1_cos_q;
  logic [15:0]     sin_turn;

  // sine taken a quarter turn back; cosine is then the sine of the raw angle
  assign sin_turn = s_axis_tdata_i - 16'd16384;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_cmd_q <= s_axis_tuser_i;
      s1_sin_q <= sine_index(sin_turn);
      s1_cos_q <= sine_index(s_axis_tdata_i);
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: table read
  // ------------------------------------------------------------------
  logic                     s2_cmd_q;
  logic signed [TRIG_W:0]   s2_sin_q, s2_cos_q;
  logic signed [TRIG_W:0]   sin_mag, cos_mag;

  assign sin_mag = $signed({1'b0, SINE_LUT[s1_sin_q.idx]});
  assign cos_mag = $signed({1'b0, SINE_LUT[s1_cos_q.idx]});

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_cmd_q <= s1_cmd_q;
      s2_sin_q <= s1_sin_q.neg ? -sin_mag : sin_mag;
      s2_cos_q <= s1_cos_q.neg ? -cos_mag : cos_mag;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: k = c * gain, one plus / minus sine
  // ------------------------------------------------------------------
  logic                   s3_cmd_q;
  logic signed [KW-1:0]   s3_k_q;
  logic [TRIG_W:0]        s3_ps_q, s3_ms_q;
  logic [TRIG_W+1:0]      ps_full, ms_full;

  assign ps_full = (TRIG_W+2)'(TRIG_ONE) + (TRIG_W+2)'(s2_sin_q);
  assign ms_full = (TRIG_W+2)'(TRIG_ONE) - (TRIG_W+2)'(s2_sin_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_cmd_q <= s2_cmd_q;
      s3_k_q   <= KW'(s2_cos_q) * KW'(depth_gain_q);
      s3_ps_q  <= ps_full[TRIG_W:0];
      s3_ms_q  <= ms_full[TRIG_W:0];
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: products with the card dimensions
  // ------------------------------------------------------------------
  logic                    s4_cmd_q;
  logic [PmW-1:0]          s4_plus_q, s4_minus_q;
  logic signed [SUM_W-1:0] s4_kd_q;
  logic [DIM_W-1:0]        dim_spin, dim_depth;

  // spin axis dimension scales (1 +/- s); the other one takes the depth term
  assign dim_spin  = s3_cmd_q ? rect_height_q : rect_width_q;
  assign dim_depth = s3_cmd_q ? rect_width_q  : rect_height_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_cmd_q   <= s3_cmd_q;
      s4_plus_q  <= PmW'(s3_ps_q) * PmW'(dim_spin);
      s4_minus_q <= PmW'(s3_ms_q) * PmW'(dim_spin);
      s4_kd_q    <= SUM_W'(s3_k_q) * SUM_W'($signed({1'b0, dim_depth}));
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: exact sums, 29 extra fraction bits
  // ------------------------------------------------------------------
  logic signed [SUM_W-1:0] s5_sum_q [N_COORD];
  logic signed [SUM_W-1:0] sum_d    [N_COORD];
  logic signed [SUM_W-1:0] lx, ty, w_full, w_half, h_full, h_half, plus, minus, kd;

  always_comb begin
    lx     = SUM_W'(rect_left_q) <<< EXTRA_BITS;
    ty     = SUM_W'(rect_top_q) <<< EXTRA_BITS;
    w_full = SUM_W'(rect_width_q) <<< EXTRA_BITS;
    w_half = SUM_W'(rect_width_q) <<< (EXTRA_BITS - 1);
    h_full = SUM_W'(rect_height_q) <<< EXTRA_BITS;
    h_half = SUM_W'(rect_height_q) <<< (EXTRA_BITS - 1);
    plus   = SUM_W'(s4_plus_q) <<< TRIG_FRAC;
    minus  = SUM_W'(s4_minus_q) <<< TRIG_FRAC;
    kd     = s4_kd_q;
    // order: centre x/y, then corners a, b, c, d as x/y pairs
    sum_d[0] = lx + w_half;
    sum_d[1] = ty + h_half;
    if (!s4_cmd_q) begin
      sum_d[2] = lx + plus;
      sum_d[3] = ty - kd;
      sum_d[4] = lx + minus;
      sum_d[5] = ty + kd;
      sum_d[6] = lx + minus;
      sum_d[7] = ty + h_full - kd;
      sum_d[8] = lx + plus;
      sum_d[9] = ty + h_full + kd;
    end else begin
      sum_d[2] = lx - kd;
      sum_d[3] = ty + plus;
      sum_d[4] = lx + w_full + kd;
      sum_d[5] = ty + plus;
      sum_d[6] = lx + w_full - kd;
      sum_d[7] = ty + minus;
      sum_d[8] = lx + kd;
      sum_d[9] = ty + minus;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < N_COORD; i++) begin
        s5_sum_q[i] <= sum_d[i];
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: round half up, saturate to 24 bits
  // ------------------------------------------------------------------
  function automatic logic [COORD_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] biased;
    logic [RndW-1:0]         hi;
    logic [COORD_W-1:0]      res;
    biased = v + (SUM_W'(1) <<< (EXTRA_BITS - 1));
    hi     = biased[SUM_W-1:EXTRA_BITS];
    if (hi[RndW-1:COORD_W-1] == '0 || hi[RndW-1:COORD_W-1] == '1) begin
      res = hi[COORD_W-1:0];
    end else if (hi[RndW-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

  logic [COORD_W-1:0] s6_coord_q [N_COORD];

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int i = 0; i < N_COORD; i++) begin
        s6_coord_q[i] <= round_sat(s5_sum_q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < N_COORD; i++) begin
      m_axis_tdata_o[i*COORD_W +: COORD_W] = s6_coord_q[i];
    end
  end

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> &v_q)
    else $error("input stalled with an empty stage in the pipe");

  a_accept_loads_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> v_q[0])
    else $error("accepted item missing from first stage");

  a_trig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (s2_sin_q <= 16'sd16384 && s2_sin_q >= -16'sd16384 &&
                s2_cos_q <= 16'sd16384 && s2_cos_q >= -16'sd16384))
    else $error("sine or cosine beyond one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && !en[NStages-1] ||
    m_axis_tready_i)
    else $error("output stage dropped a waiting item");

endmodule
